// ----- src/wes_pkg.sv -----
// Shared types, constants and helpers for the wind estimate store.
`timescale 1ns / 1ps
package wes_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] Q_MAX = 3'd5;
  localparam int QUAL_GAIN = 100;
  localparam int ALT_GAIN = 100;
  localparam int TIME_GAIN = 200;
  localparam int FAC_A = 2 * ALT_GAIN;
  localparam int FAC_T = 2 * TIME_GAIN;
  localparam int Q_SCALE = QUAL_GAIN / 5;

  localparam int WQ_W  = 14;                    // q*20*a, at most 10000
  localparam int W_W   = 21;                    // weight, at most 2000000
  localparam int TOT_W = W_W + CNT_W;
  localparam int SUM_W = 16 + W_W + CNT_W;
  localparam int DIV_W = 48;
  localparam int DIV_SH_W = 64;
  localparam int QUO_W = 16;
  localparam int SHORT_STEPS = 8;
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [15:0] ALT_RANGE_RST  = 16'd1000;
  localparam logic [15:0] TIME_RANGE_RST = 16'd3600;

  // Configuration register indexes
  localparam logic REG_ALT_RANGE  = 1'b0;
  localparam logic REG_TIME_RANGE = 1'b1;

  // Divider operand selects
  localparam logic [1:0] DIV_A = 2'd0;
  localparam logic [1:0] DIV_T = 2'd1;
  localparam logic [1:0] DIV_X = 2'd2;
  localparam logic [1:0] DIV_Y = 2'd3;

  typedef struct packed {
    logic signed [15:0] east;
    logic signed [15:0] north;
    logic signed [15:0] alt;
    logic [31:0]        tstamp;
    logic [2:0]         qual;
  } entry_t;

  typedef struct packed {
    logic       load_in;
    logic       mem_wr;
    logic       mem_rd;
    logic       scan_init;
    logic       scan_eval;
    logic       idx_dec;
    logic       idx_inc;
    logic       q_init;
    logic       q_eval;
    logic       m1;
    logic       m2;
    logic       m3;
    logic       div_start;
    logic [1:0] div_sel;
    logic       aq_load;
    logic       tq_load;
    logic       w1;
    logic       w2;
    logic       acc1;
    logic       acc2;
    logic       mx_load;
    logic       my_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic op_query;
    logic full;
    logic count_zero;
    logic idx_zero;
    logic idx_last;
    logic qual;
    logic div_done;
    logic tot_nz;
    logic out_free;
  } sts_t;

  // Eviction penalty 600*(6-q)
  function automatic logic [11:0] quality_penalty(input logic [2:0] q);
    logic [11:0] p;
    case (q)
      3'd0:    p = 12'd3600;
      3'd1:    p = 12'd3000;
      3'd2:    p = 12'd2400;
      3'd3:    p = 12'd1800;
      3'd4:    p = 12'd1200;
      3'd5:    p = 12'd600;
      default: p = 12'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- src/wes_div.sv -----
// Restoring divider, one quotient bit per cycle, 8 or 16 quotient bits.
`timescale 1ns / 1ps
module wes_div
  import wes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             long_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  logic [DIV_W-1:0]    rem_q;
  logic [DIV_SH_W-1:0] ds_q;
  logic [QUO_W-1:0]    quo_q;
  logic [STEP_W-1:0]   cnt_q;
  logic                run_q;
  logic                done_q;
  logic [DIV_SH_W-1:0] rem_ext;
  logic [DIV_SH_W-1:0] diff;
  logic                ge;

  assign rem_ext = DIV_SH_W'(rem_q);
  assign diff    = rem_ext - ds_q;
  assign ge      = rem_ext >= ds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= long_i ? STEP_W'(QUO_W - 1) : STEP_W'(SHORT_STEPS - 1);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      ds_q  <= long_i ? (DIV_SH_W'(den_i) << (QUO_W - 1))
                      : (DIV_SH_W'(den_i) << (SHORT_STEPS - 1));
      quo_q <= '0;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= diff[DIV_W-1:0];
      end
      quo_q <= {quo_q[QUO_W-2:0], ge};
      ds_q  <= ds_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- src/wes_ctrl.sv -----
// Sequencer for add, eviction scan and weighted mean query.
`timescale 1ns / 1ps
module wes_ctrl
  import wes_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_WR    = 5'd2;
  localparam logic [4:0] S_EINIT = 5'd3;
  localparam logic [4:0] S_ERD   = 5'd4;
  localparam logic [4:0] S_EEV   = 5'd5;
  localparam logic [4:0] S_QINIT = 5'd6;
  localparam logic [4:0] S_QRD   = 5'd7;
  localparam logic [4:0] S_QEV   = 5'd8;
  localparam logic [4:0] S_M1    = 5'd9;
  localparam logic [4:0] S_M2    = 5'd10;
  localparam logic [4:0] S_M3    = 5'd11;
  localparam logic [4:0] S_DA    = 5'd12;
  localparam logic [4:0] S_DAW   = 5'd13;
  localparam logic [4:0] S_DTW   = 5'd14;
  localparam logic [4:0] S_W1    = 5'd15;
  localparam logic [4:0] S_W2    = 5'd16;
  localparam logic [4:0] S_AC1   = 5'd17;
  localparam logic [4:0] S_AC2   = 5'd18;
  localparam logic [4:0] S_NEXT  = 5'd19;
  localparam logic [4:0] S_FIN   = 5'd20;
  localparam logic [4:0] S_FXW   = 5'd21;
  localparam logic [4:0] S_FYW   = 5'd22;
  localparam logic [4:0] S_OUT   = 5'd23;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.op_query) begin
          state_d = S_QINIT;
        end else if (sts_i.full) begin
          state_d = S_EINIT;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        cmd_o.mem_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_EINIT: begin
        cmd_o.scan_init = 1'b1;
        state_d = S_ERD;
      end
      S_ERD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_EEV;
      end
      S_EEV: begin
        cmd_o.scan_eval = 1'b1;
        if (sts_i.idx_zero) begin
          state_d = S_WR;
        end else begin
          cmd_o.idx_dec = 1'b1;
          state_d = S_ERD;
        end
      end
      S_QINIT: begin
        cmd_o.q_init = 1'b1;
        state_d = sts_i.count_zero ? S_FIN : S_QRD;
      end
      S_QRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_QEV;
      end
      S_QEV: begin
        cmd_o.q_eval = 1'b1;
        state_d = S_M1;
      end
      S_M1: begin
        if (sts_i.qual) begin
          cmd_o.m1 = 1'b1;
          state_d = S_M2;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_M2: begin
        cmd_o.m2 = 1'b1;
        state_d = S_M3;
      end
      S_M3: begin
        cmd_o.m3 = 1'b1;
        state_d = S_DA;
      end
      S_DA: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_A;
        state_d = S_DAW;
      end
      S_DAW: begin
        if (sts_i.div_done) begin
          cmd_o.aq_load   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_T;
          state_d = S_DTW;
        end
      end
      S_DTW: begin
        if (sts_i.div_done) begin
          cmd_o.tq_load = 1'b1;
          state_d = S_W1;
        end
      end
      S_W1: begin
        cmd_o.w1 = 1'b1;
        state_d = S_W2;
      end
      S_W2: begin
        cmd_o.w2 = 1'b1;
        state_d = S_AC1;
      end
      S_AC1: begin
        cmd_o.acc1 = 1'b1;
        state_d = S_AC2;
      end
      S_AC2: begin
        cmd_o.acc2 = 1'b1;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (sts_i.idx_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_QRD;
        end
      end
      S_FIN: begin
        if (sts_i.tot_nz) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_X;
          state_d = S_FXW;
        end else begin
          state_d = S_OUT;
        end
      end
      S_FXW: begin
        if (sts_i.div_done) begin
          cmd_o.mx_load   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_Y;
          state_d = S_FYW;
        end
      end
      S_FYW: begin
        if (sts_i.div_done) begin
          cmd_o.my_load = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/wes_dp.sv -----
// Datapath: entry memory, weight arithmetic, sums and output register.
`timescale 1ns / 1ps
module wes_dp
  import wes_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               operation_i,
  input  logic [31:0]        now_seconds_i,
  input  logic signed [15:0] altitude_m_i,
  input  logic signed [15:0] wind_east_i,
  input  logic signed [15:0] wind_north_i,
  input  logic [2:0]         meas_quality_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               found_o,
  output logic signed [15:0] mean_east_o,
  output logic signed [15:0] mean_north_o
);

  logic [15:0] alt_range_q, time_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_range_q  <= ALT_RANGE_RST;
      time_range_q <= TIME_RANGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ALT_RANGE:  alt_range_q  <= cfg_data_i;
        REG_TIME_RANGE: time_range_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input item
  logic               op_q;
  logic [31:0]        now_q;
  logic signed [15:0] alt_q, east_q, north_q;
  logic [2:0]         qin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q    <= operation_i;
      now_q   <= now_seconds_i;
      alt_q   <= altitude_m_i;
      east_q  <= wind_east_i;
      north_q <= wind_north_i;
      qin_q   <= meas_quality_i;
    end
  end

  // Entry count and walk index
  logic [CNT_W-1:0] count_q, cnt_m1;
  logic [IDX_W-1:0] idx_q, victim_q, waddr;
  logic             full;

  assign cnt_m1 = count_q - CNT_W'(1);
  assign full   = (count_q == CNT_W'(MAX_ENTRIES));
  assign waddr  = full ? victim_q : count_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.mem_wr && !full) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      idx_q <= cnt_m1[IDX_W-1:0];
    end else if (cmd_i.q_init) begin
      idx_q <= '0;
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_q - IDX_W'(1);
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // Entry memory
  entry_t mem_q [MAX_ENTRIES];
  entry_t rd_q;
  entry_t wentry;

  always_comb begin
    wentry.east   = east_q;
    wentry.north  = north_q;
    wentry.alt    = alt_q;
    wentry.tstamp = now_q;
    wentry.qual   = (qin_q > Q_MAX) ? Q_MAX : qin_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[waddr] <= wentry;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[idx_q];
    end
  end

  // Eviction scan: first strict maximum of the score, walking downward
  logic [32:0]        tdiff_s;
  logic signed [34:0] score_d, best_q;

  assign tdiff_s = {1'b0, now_q} - {1'b0, rd_q.tstamp};
  assign score_d = {{2{tdiff_s[32]}}, tdiff_s} + {23'b0, quality_penalty(rd_q.qual)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      best_q   <= '0;
      victim_q <= cnt_m1[IDX_W-1:0];
    end else if (cmd_i.scan_eval && (score_d > best_q)) begin
      best_q   <= score_d;
      victim_q <= idx_q;
    end
  end

  // Query: distance tests
  logic [16:0] dalt, ad;
  logic [31:0] tabs;
  logic        qual_q;
  logic [15:0] ad_q, t_q;

  assign dalt = {alt_q[15], alt_q} - {rd_q.alt[15], rd_q.alt};
  assign ad   = dalt[16] ? (17'd0 - dalt) : dalt;
  assign tabs = (now_q >= rd_q.tstamp) ? (now_q - rd_q.tstamp) : (rd_q.tstamp - now_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_eval) begin
      qual_q <= (ad < {1'b0, alt_range_q}) && (tabs < {16'b0, time_range_q});
      ad_q   <= ad[15:0];
      t_q    <= tabs[15:0];
    end
  end

  // Query: ratio operands
  logic [31:0]      r2_q, d2_q, t2_q, tr2_q, trt_q, adiff_q;
  logic [32:0]      asum_q;
  logic [40:0]      tden_q, trt4_q;
  logic [DIV_W-1:0] anum_q, aden_q, tnum_q, tden2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.m1) begin
      r2_q  <= 32'(alt_range_q) * 32'(alt_range_q);
      d2_q  <= 32'(ad_q) * 32'(ad_q);
      t2_q  <= 32'(t_q) * 32'(t_q);
      tr2_q <= 32'(time_range_q) * 32'(time_range_q);
      trt_q <= 32'(time_range_q) * (32'(time_range_q) - 32'(t_q));
    end
    if (cmd_i.m2) begin
      asum_q  <= {1'b0, r2_q} + {1'b0, d2_q};
      adiff_q <= r2_q - d2_q;
      tden_q  <= 41'(t2_q) * 41'(FAC_T) + 41'(tr2_q);
      trt4_q  <= 41'(trt_q) * 41'(FAC_T);
    end
    if (cmd_i.m3) begin
      anum_q  <= DIV_W'(adiff_q) * DIV_W'(FAC_A) + DIV_W'(asum_q);
      aden_q  <= DIV_W'(asum_q) << 1;
      tnum_q  <= DIV_W'(trt4_q) + DIV_W'(tden_q);
      tden2_q <= DIV_W'(tden_q) << 1;
    end
  end

  // Shared divider
  logic [SUM_W-1:0] sx_q, sy_q;
  logic [TOT_W-1:0] tot_q;
  logic [SUM_W-1:0] ax, ay;
  logic [DIV_W-1:0] dnum, dden;
  logic             ddone;
  logic [QUO_W-1:0] quo;

  assign ax = sx_q[SUM_W-1] ? (SUM_W'(0) - sx_q) : sx_q;
  assign ay = sy_q[SUM_W-1] ? (SUM_W'(0) - sy_q) : sy_q;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_A: begin
        dnum = anum_q;
        dden = aden_q;
      end
      DIV_T: begin
        dnum = tnum_q;
        dden = tden2_q;
      end
      DIV_X: begin
        dnum = DIV_W'(ax);
        dden = DIV_W'(tot_q);
      end
      DIV_Y: begin
        dnum = DIV_W'(ay);
        dden = DIV_W'(tot_q);
      end
      default: begin
        dnum = anum_q;
        dden = aden_q;
      end
    endcase
  end

  wes_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .long_i  (cmd_i.div_sel == DIV_X || cmd_i.div_sel == DIV_Y),
    .num_i   (dnum),
    .den_i   (dden),
    .done_o  (ddone),
    .quo_o   (quo)
  );

  // Weight and weighted sums
  logic [7:0]          aq_q, tq_q;
  logic [6:0]          q20;
  logic [WQ_W-1:0]     wq_q;
  logic [W_W-1:0]      wprod;
  logic [W_W-1:0]      w_q;
  logic signed [37:0]  px_d, py_d, px_q, py_q;
  logic signed [15:0]  mx_q, my_q;

  assign q20   = 7'(rd_q.qual) * 7'(Q_SCALE);
  assign wprod = W_W'(wq_q) * W_W'(tq_q);
  assign px_d  = 38'($signed(rd_q.east)) * 38'($signed({1'b0, w_q}));
  assign py_d  = 38'($signed(rd_q.north)) * 38'($signed({1'b0, w_q}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.aq_load) begin
      aq_q <= quo[7:0];
    end
    if (cmd_i.tq_load) begin
      tq_q <= quo[7:0];
    end
    if (cmd_i.w1) begin
      wq_q <= WQ_W'(q20) * WQ_W'(aq_q);
    end
    if (cmd_i.w2) begin
      w_q <= wprod;
    end
    if (cmd_i.acc1) begin
      px_q <= px_d;
      py_q <= py_d;
    end
    if (cmd_i.q_init) begin
      sx_q  <= '0;
      sy_q  <= '0;
      tot_q <= '0;
    end else if (cmd_i.acc2) begin
      sx_q  <= sx_q + SUM_W'(px_q);
      sy_q  <= sy_q + SUM_W'(py_q);
      tot_q <= tot_q + TOT_W'(w_q);
    end
    // truncate toward zero: divide magnitudes, then restore the sign
    if (cmd_i.mx_load) begin
      mx_q <= sx_q[SUM_W-1] ? (16'd0 - quo) : quo;
    end
    if (cmd_i.my_load) begin
      my_q <= sy_q[SUM_W-1] ? (16'd0 - quo) : quo;
    end
  end

  // Output register
  logic               out_valid_q, found_q;
  logic signed [15:0] oe_q, on_q;
  logic               tot_nz;

  assign tot_nz = (tot_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      found_q <= tot_nz;
      oe_q    <= tot_nz ? mx_q : 16'sd0;
      on_q    <= tot_nz ? my_q : 16'sd0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign mean_east_o  = oe_q;
  assign mean_north_o = on_q;

  always_comb begin
    sts_o.op_query   = op_q;
    sts_o.full       = full;
    sts_o.count_zero = (count_q == '0);
    sts_o.idx_zero   = (idx_q == '0);
    sts_o.idx_last   = (idx_q == cnt_m1[IDX_W-1:0]);
    sts_o.qual       = qual_q;
    sts_o.div_done   = ddone;
    sts_o.tot_nz     = tot_nz;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

// ----- src/wind_estimate_store.sv -----
// Wind estimate store: top level joining the sequencer and the datapath.
//
// Input stream (s_axis): tuser selects add (0) or query (1); tdata carries
// time, altitude, wind vector and quality. An add stores one entry and gives
// no item back; a query gives exactly one item on m_axis with found in tuser
// and the weighted mean wind in tdata.
// Items are handled one at a time; tready is high only while idle.
// An add into a store with room passes through dispatch and write; into a
// full store it first scans every entry for the one to replace, reading
// and scoring each in turn. A query walks all N stored entries through one
// memory read port and one shared bit-serial divider: an entry out of range
// is only read and tested, one in range also takes two 8-step divisions and
// the weight and sum updates; the two 16-step mean divisions follow when the
// total weight is nonzero.
// Reset empties the store and loads the range registers with 1000 m and
// 3600 s; no clearing pass is needed. The configuration port writes at once.
// The result waits in an output register; while the receiver stalls, a new
// item is still taken, and the next query holds its result until that
// register is free.
`timescale 1ns / 1ps
module wind_estimate_store
  import wes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // now_seconds[31:0], altitude_m[47:32], wind_east[63:48],
  // wind_north[79:64], meas_quality[82:80], zero fill to 88
  input  logic [87:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // mean_east[15:0], mean_north[31:16]
  output logic        m_axis_tuser    // found
);

  cmd_t               cmd;
  sts_t               sts;
  logic signed [15:0] mean_east, mean_north;

  wes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wes_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (s_axis_tuser),
    .now_seconds_i  (s_axis_tdata[31:0]),
    .altitude_m_i   (s_axis_tdata[47:32]),
    .wind_east_i    (s_axis_tdata[63:48]),
    .wind_north_i   (s_axis_tdata[79:64]),
    .meas_quality_i (s_axis_tdata[82:80]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .found_o        (m_axis_tuser),
    .mean_east_o    (mean_east),
    .mean_north_o   (mean_north)
  );

  assign m_axis_tdata = {mean_north, mean_east};

endmodule

// ----- src/wes_chk.sv -----
// Port checker for the wind estimate store, bound to the top level.
`timescale 1ns / 1ps
module wes_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("nonzero mean without a qualifying entry");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again before the item was handled");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result item appeared while idle");

endmodule

bind wind_estimate_store wes_chk u_wes_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/wind_estimate_checker.sv -----
// Checker for the wind estimate store: predicts every query result and compares it.
`timescale 1ns / 1ps
module wind_estimate_checker
  import wes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  // now_seconds, altitude_m, wind_east, wind_north, meas_quality, zero fill
  input  logic [87:0] s_data_i,
  input  logic        s_user_i,   // operation
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [31:0] m_data_i,   // mean_east, mean_north
  input  logic        m_user_i,   // found
  output int          fail_cnt_o,
  output int          pending_o,
  output int          hits_o
);

  typedef struct {
    logic               found;
    logic signed [15:0] east;
    logic signed [15:0] north;
  } mean_t;

  mean_t mean_due[$];

  logic [15:0]        alt_rng;
  logic [15:0]        time_rng;
  int                 n_stored;
  logic signed [15:0] st_east[MAX_ENTRIES];
  logic signed [15:0] st_north[MAX_ENTRIES];
  logic signed [15:0] st_alt[MAX_ENTRIES];
  logic [31:0]        st_time[MAX_ENTRIES];
  logic [2:0]         st_qual[MAX_ENTRIES];

  // Highest score wins, scanning down; ties keep the higher slot.
  function automatic int evict_slot(input logic [31:0] now);
    longint best;
    longint score;
    int     slot;
    best = 0;
    slot = n_stored - 1;
    for (int i = n_stored - 1; i >= 0; i--) begin
      score = 600 * (6 - longint'(st_qual[i])) + longint'(now) - longint'(st_time[i]);
      if (score > best) begin
        best = score;
        slot = i;
      end
    end
    return slot;
  endfunction

  function automatic mean_t weighted_mean(input logic [31:0] now, input logic signed [15:0] alt);
    mean_t           res;
    longint unsigned r2, tr, ad, t, d2, asum, aq, den, tq, w;
    longint          d, sx, sy, total;
    sx = 0;
    sy = 0;
    total = 0;
    r2 = longint'(alt_rng) * longint'(alt_rng);
    tr = time_rng;
    for (int i = 0; i < n_stored; i++) begin
      d  = longint'(alt) - longint'(st_alt[i]);
      ad = (d < 0) ? -d : d;
      t  = (now >= st_time[i]) ? longint'(now - st_time[i]) : longint'(st_time[i] - now);
      if (!(ad < alt_rng && t < tr)) continue;
      d2   = ad * ad;
      asum = r2 + d2;
      aq   = (200 * (r2 - d2) + asum) / (2 * asum);
      den  = 400 * t * t + tr * tr;
      tq   = (400 * tr * (tr - t) + den) / (2 * den);
      w    = longint'(st_qual[i]) * 20 * aq * tq;
      sx += longint'(st_east[i]) * longint'(w);
      sy += longint'(st_north[i]) * longint'(w);
      total += longint'(w);
    end
    if (total > 0) begin
      res.found = 1'b1;
      res.east  = 16'(sx / total);
      res.north = 16'(sy / total);
    end else begin
      res.found = 1'b0;
      res.east  = '0;
      res.north = '0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mean_t      exp_m;
    int         slot;
    logic [2:0] q;
    if (!rst_ni) begin
      alt_rng    = ALT_RANGE_RST;
      time_rng   = TIME_RANGE_RST;
      n_stored   = 0;
      fail_cnt_o = 0;
      hits_o     = 0;
      mean_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ALT_RANGE:  alt_rng = cfg_data_i;
          REG_TIME_RANGE: time_rng = cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        if (s_user_i) begin
          mean_due.push_back(weighted_mean(s_data_i[31:0], s_data_i[47:32]));
        end else begin
          if (n_stored >= MAX_ENTRIES) begin
            slot = evict_slot(s_data_i[31:0]);
          end else begin
            slot = n_stored;
            n_stored++;
          end
          q = s_data_i[82:80];
          st_east[slot]  = s_data_i[63:48];
          st_north[slot] = s_data_i[79:64];
          st_alt[slot]   = s_data_i[47:32];
          st_time[slot]  = s_data_i[31:0];
          st_qual[slot]  = (q > Q_MAX) ? Q_MAX : q;
        end
      end
      if (m_valid_i && m_ready_i) begin
        if (mean_due.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: unexpected item found=%0b data=%h", $time, m_user_i, m_data_i);
        end else begin
          exp_m = mean_due.pop_front();
          if (exp_m.found) hits_o++;
          if (m_user_i !== exp_m.found || m_data_i[15:0] !== exp_m.east ||
              m_data_i[31:16] !== exp_m.north) begin
            fail_cnt_o++;
            $display("%0t: expected found=%0b east=%0d north=%0d, got found=%0b east=%0d north=%0d",
                     $time, exp_m.found, exp_m.east, exp_m.north, m_user_i,
                     $signed(m_data_i[15:0]), $signed(m_data_i[31:16]));
          end
        end
      end
    end
    pending_o = mean_due.size();
  end

endmodule

// ----- verif/wind_estimate_store_test.sv -----
// Testbench top for the wind estimate store: stimulus, idling and verdict.
`timescale 1ns / 1ps
module wind_estimate_store_test
  import wes_pkg::*;
();

  localparam int WATCHDOG = 30000;
  localparam int SETTLE = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_cnt, pending, hits;
  int send_idle, recv_idle;
  int hold_req, idle_cycles;
  int n_items, n_queries;
  int cur_time, base_alt;
  logic [15:0] alt_set, time_set;

  wind_estimate_store dut (.*);

  wind_estimate_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_user_i(m_axis_tuser),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .hits_o(hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 2000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [31:0] now, input logic [15:0] alt,
                           input logic [15:0] east, input logic [15:0] north,
                           input logic [2:0] qual);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, qual, north, east, alt, now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_items++;
    if (op) n_queries++;
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed: altitudes and times near the current ones.
  task automatic random_item(input logic force_query);
    int          span, alt, tstep;
    logic [31:0] now;
    logic        op;
    op = force_query || ($urandom_range(99) < 40);
    span = (alt_set > 4000) ? 4000 : alt_set + 1;
    if ($urandom_range(99) < 25) alt = int'($urandom_range(34815)) - 2048;
    else alt = base_alt + int'($urandom_range(2 * span)) - span;
    if (alt < -2048) alt = -2048;
    if (alt > 32767) alt = 32767;
    tstep = (time_set / 16) + 1;
    case ($urandom_range(19))
      0:       now = cur_time - $urandom_range(tstep);
      1:       begin cur_time += $urandom_range(100000); now = cur_time; end
      default: begin cur_time += $urandom_range(tstep); now = cur_time; end
    endcase
    if ($urandom_range(99) < 5) base_alt = int'($urandom_range(30000));
    send_item(op, now, 16'(alt), 16'($urandom), 16'($urandom), 3'($urandom_range(7)));
  endtask

  initial begin
    logic [15:0] alts[6], times[6];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ALT_RANGE;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    send_idle = 17;
    recv_idle = 85;
    hold_req = 0;
    idle_cycles = 0;
    n_items = 0;
    n_queries = 0;
    alt_set = ALT_RANGE_RST;
    time_set = TIME_RANGE_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, field extremes, every quality, time going backwards.
    send_item(1'b1, 32'd0, 16'd0, 16'd0, 16'd0, 3'd0);
    send_item(1'b0, 32'd100, 16'd0, 16'h7fff, 16'h8000, 3'd5);
    send_item(1'b0, 32'd100, 16'd0, 16'h8000, 16'h7fff, 3'd7);
    send_item(1'b1, 32'd100, 16'd0, 16'd0, 16'd0, 3'd0);
    send_item(1'b0, 32'd200, 16'd999, 16'h1234, 16'hfedc, 3'd0);
    send_item(1'b1, 32'd200, 16'd0, 16'd0, 16'd0, 3'd0);
    for (int q = 1; q <= 6; q++)
      send_item(1'b0, 32'd300 + q, 16'(100 * q), 16'(q * 300), 16'(-q * 200), 3'(q));
    send_item(1'b1, 32'd3700, 16'd0, 16'd0, 16'd0, 3'd0);
    send_item(1'b1, 32'd3699, 16'd1000, 16'd0, 16'd0, 3'd0);
    send_item(1'b1, 32'd50, 16'd300, 16'd0, 16'd0, 3'd0);
    send_item(1'b0, 32'hffffffff, 16'h7fff, 16'hffff, 16'h0001, 3'd4);
    send_item(1'b0, 32'hffffffff, 16'hf800, 16'h0001, 16'hffff, 3'd6);
    send_item(1'b1, 32'hfffffff0, 16'h7fff, 16'd0, 16'd0, 3'd0);
    send_item(1'b1, 32'hffffffff, 16'hf800, 16'hffff, 16'hffff, 3'd7);
    send_item(1'b1, 32'd0, 16'h7fff, 16'hffff, 16'hffff, 3'd7);
    drain();

    alts  = '{16'd1000, 16'd1, 16'd65535, 16'd0, 16'd500, 16'($urandom_range(1, 65535))};
    times = '{16'd3600, 16'd1, 16'd65535, 16'd3600, 16'd0, 16'($urandom_range(1, 65535))};
    cur_time = 1000;
    base_alt = 500;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle = 85; recv_idle = 17; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      if (ph == 5) cur_time = 32'hfff00000;
      alt_set = alts[ph];
      time_set = times[ph];
      write_cfg(REG_ALT_RANGE, alt_set);
      write_cfg(REG_TIME_RANGE, time_set);
      if (ph == 1) begin
        // Long receiver hold-off while queries keep coming: fill up and stall.
        hold_req++;
        for (int k = 0; k < 8; k++) random_item(1'b1);
        drain();
      end
      for (int k = 0; k < 190; k++) begin
        random_item(1'b0);
        if (k == 95) drain();
      end
      drain();
    end

    $display("Sent %0d items (%0d queries) over 6 range settings; %0d queries found entries.",
             n_items, n_queries, hits);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/wes_pkg.sv
src/wes_div.sv
src/wes_ctrl.sv
src/wes_dp.sv
src/wind_estimate_store.sv
src/wes_chk.sv
verif/wind_estimate_checker.sv
verif/wind_estimate_store_test.sv
